// ----- sv/ddbt_pkg.sv -----
// ----------------------------------------------------------------------------
// ddbt_pkg
// Shared types and constants of the display idle dim and blank timer.
// ----------------------------------------------------------------------------
package ddbt_pkg;

    localparam int unsigned TIMEOUT_W = 32;
    localparam int unsigned ELAPSED_W = 16;
    localparam int unsigned HOUR_W    = 5;
    localparam int unsigned MODE_W    = 2;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [MODE_W-1:0] MODE_ACTIVE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DIMMED = 2'd1;
    localparam logic [MODE_W-1:0] MODE_OFF    = 2'd2;

    localparam logic OP_TICK     = 1'b0;
    localparam logic OP_ACTIVITY = 1'b1;

    localparam logic [TIMEOUT_W:0]   RAISE_MS    = 33'd1000;
    localparam logic [TIMEOUT_W-1:0] SAT_IDLE    = 32'hFFFF_FFFF;
    localparam logic [TIMEOUT_W-1:0] MIN_DIM     = 32'd1;

    localparam logic [TIMEOUT_W-1:0] RST_DIM_MS   = 32'd30000;
    localparam logic [TIMEOUT_W-1:0] RST_BLANK_MS = 32'd60000;
    localparam logic [TIMEOUT_W-1:0] RST_SLEEP_MS = 32'd0;
    localparam logic [HOUR_W-1:0]    RST_NIGHT_START = 5'd22;
    localparam logic [HOUR_W-1:0]    RST_NIGHT_END   = 5'd7;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIM_TIMEOUT   = 3'd0,
        CFG_BLANK_TIMEOUT = 3'd1,
        CFG_SLEEP_TIMEOUT = 3'd2,
        CFG_NIGHT_START   = 3'd3,
        CFG_NIGHT_END     = 3'd4,
        CFG_AUTO_DIM      = 3'd5,
        CFG_DEEP_SLEEP    = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [TIMEOUT_W-1:0] dim_after_ms;
        logic [TIMEOUT_W-1:0] off_after_ms;
        logic [TIMEOUT_W-1:0] sleep_timeout_ms;
        logic [HOUR_W-1:0]    night_first_hr;
        logic [HOUR_W-1:0]    night_stop_hr;
        logic                 auto_dim_enable;
        logic                 deep_sleep_enable;
    } t_cfg;

    typedef struct packed {
        logic [MODE_W-1:0] display_mode;
        logic              mode_changed;
        logic              sleep_request;
    } t_result;

endpackage

// ----- sv/ddbt_cfg.sv -----
// ----------------------------------------------------------------------------
// ddbt_cfg
// Configuration register file written through a plain write port.
// ----------------------------------------------------------------------------
module ddbt_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ddbt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ddbt_pkg::TIMEOUT_W-1:0] i_cfg_wdata,
    output ddbt_pkg::t_cfg                o_cfg
);
    import ddbt_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dim_after_ms      <= RST_DIM_MS;
            r_cfg.off_after_ms      <= RST_BLANK_MS;
            r_cfg.sleep_timeout_ms  <= RST_SLEEP_MS;
            r_cfg.night_first_hr    <= RST_NIGHT_START;
            r_cfg.night_stop_hr     <= RST_NIGHT_END;
            r_cfg.auto_dim_enable   <= 1'b1;
            r_cfg.deep_sleep_enable <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_DIM_TIMEOUT:   r_cfg.dim_after_ms      <= i_cfg_wdata;
                CFG_BLANK_TIMEOUT: r_cfg.off_after_ms      <= i_cfg_wdata;
                CFG_SLEEP_TIMEOUT: r_cfg.sleep_timeout_ms  <= i_cfg_wdata;
                CFG_NIGHT_START:   r_cfg.night_first_hr    <= i_cfg_wdata[HOUR_W-1:0];
                CFG_NIGHT_END:     r_cfg.night_stop_hr     <= i_cfg_wdata[HOUR_W-1:0];
                CFG_AUTO_DIM:      r_cfg.auto_dim_enable   <= i_cfg_wdata[0];
                CFG_DEEP_SLEEP:    r_cfg.deep_sleep_enable <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- sv/ddbt_core.sv -----
// ----------------------------------------------------------------------------
// ddbt_core
// Idle counter and display mode state with the per-item decision logic.
// ----------------------------------------------------------------------------
module ddbt_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ddbt_pkg::t_cfg                i_cfg,
    input  logic                          i_commit,
    input  logic                          i_opcode,
    input  logic [ddbt_pkg::ELAPSED_W-1:0] i_elapsed_ms,
    input  logic [ddbt_pkg::HOUR_W-1:0]    i_hour_now,
    output ddbt_pkg::t_result             o_result
);
    import ddbt_pkg::*;

    logic [TIMEOUT_W-1:0] r_idle;
    logic [MODE_W-1:0]    r_mode;
    logic [TIMEOUT_W-1:0] n_idle;
    logic [MODE_W-1:0]    n_mode;

    logic [TIMEOUT_W:0]   sum;
    logic [TIMEOUT_W-1:0] tick_idle;
    logic                 night;
    logic [TIMEOUT_W-1:0] dim_half;
    logic [TIMEOUT_W-1:0] dim_eff;
    logic [TIMEOUT_W-1:0] blank_half;
    logic [TIMEOUT_W:0]   blank_eff;
    logic [MODE_W-1:0]    tick_mode;
    logic                 tick_sleep;

    always_comb begin
        sum       = {1'b0, r_idle} + {{(TIMEOUT_W + 1 - ELAPSED_W){1'b0}}, i_elapsed_ms};
        tick_idle = sum[TIMEOUT_W] ? SAT_IDLE : sum[TIMEOUT_W-1:0];

        if (i_cfg.night_first_hr == i_cfg.night_stop_hr) begin
            night = 1'b0;
        end else if (i_cfg.night_first_hr < i_cfg.night_stop_hr) begin
            night = (i_hour_now >= i_cfg.night_first_hr) &&
                    (i_hour_now < i_cfg.night_stop_hr);
        end else begin
            night = (i_hour_now >= i_cfg.night_first_hr) ||
                    (i_hour_now < i_cfg.night_stop_hr);
        end

        dim_half   = night ? (i_cfg.dim_after_ms >> 1) : i_cfg.dim_after_ms;
        blank_half = night ? (i_cfg.off_after_ms >> 1) : i_cfg.off_after_ms;
        dim_eff    = (dim_half == '0) ? MIN_DIM : dim_half;
        blank_eff  = (blank_half <= dim_eff) ? ({1'b0, dim_eff} + RAISE_MS)
                                             : {1'b0, blank_half};

        if (!i_cfg.auto_dim_enable) begin
            tick_mode = MODE_ACTIVE;
        end else if ({1'b0, tick_idle} >= blank_eff) begin
            tick_mode = MODE_OFF;
        end else if (tick_idle >= dim_eff) begin
            tick_mode = MODE_DIMMED;
        end else begin
            tick_mode = MODE_ACTIVE;
        end

        tick_sleep = i_cfg.deep_sleep_enable && (i_cfg.sleep_timeout_ms != '0) &&
                     (tick_mode == MODE_OFF) && (tick_idle >= i_cfg.sleep_timeout_ms) &&
                     night;

        if (i_opcode == OP_ACTIVITY) begin
            n_idle = '0;
            n_mode = MODE_ACTIVE;
            o_result.sleep_request = 1'b0;
        end else begin
            n_idle = tick_idle;
            n_mode = tick_mode;
            o_result.sleep_request = tick_sleep;
        end
        o_result.display_mode = n_mode;
        o_result.mode_changed = (n_mode != r_mode);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle <= '0;
            r_mode <= MODE_ACTIVE;
        end else if (i_commit) begin
            r_idle <= n_idle;
            r_mode <= n_mode;
        end
    end

    a_mode_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_ACTIVE) || (r_mode == MODE_DIMMED) || (r_mode == MODE_OFF))
        else $error("display mode register holds an unused code");

    a_activity_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_commit && (i_opcode == OP_ACTIVITY) |=> (r_idle == '0) && (r_mode == MODE_ACTIVE))
        else $error("activity did not clear the idle counter");

    a_tick_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_commit && (i_opcode == OP_TICK) |=> (r_idle >= $past(r_idle)))
        else $error("idle counter went backward on a tick");

    a_sleep_only_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_commit && o_result.sleep_request |-> (o_result.display_mode == MODE_OFF) && night)
        else $error("sleep request outside the off mode or the night window");

    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_commit |=> $stable(r_idle) && $stable(r_mode))
        else $error("state changed without a committed item");

endmodule

// ----- sv/display_idle_dim_blank_timer.sv -----
// ----------------------------------------------------------------------------
// display_idle_dim_blank_timer
// Display inactivity power manager with dim, blank and deep sleep request.
// ----------------------------------------------------------------------------
// Items arrive on the input channel (i_in_valid, o_in_stall): a tick carries
// the elapsed milliseconds and the hour, an activity event clears idle time.
// Each item yields exactly one result on the output channel (o_out_valid,
// i_out_stall): the display mode after the item, a changed flag and a sleep
// request flag.
// An item sits in the input register, where the decision logic and the idle
// counter update run, and its result is then shown from the output register.
// One item can be transferred in every cycle unless the input channel stalls;
// the idle counter and mode are updated in the cycle an item moves to the
// output register, so the next item sees them at once.
// When the receiver stalls, the result holds and the input register keeps one
// more item; the input channel stalls only when both are full.
// Configuration registers are written through i_cfg_we, i_cfg_index and
// i_cfg_wdata; the user must write them only while no item is in flight, as
// the block does not enforce this. Reset restores the register defaults,
// clears idle time, sets the mode to active and empties both stages.
// ----------------------------------------------------------------------------
module display_idle_dim_blank_timer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ddbt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ddbt_pkg::TIMEOUT_W-1:0] i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_opcode,
    input  logic [ddbt_pkg::ELAPSED_W-1:0] i_elapsed_ms,
    input  logic [ddbt_pkg::HOUR_W-1:0]    i_hour_now,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [ddbt_pkg::MODE_W-1:0]    o_display_mode,
    output logic                          o_mode_changed,
    output logic                          o_sleep_request
);
    import ddbt_pkg::*;

    t_cfg    cfg;
    t_result result;

    logic                 r_s1_valid;
    logic                 r_s1_opcode;
    logic [ELAPSED_W-1:0] r_s1_elapsed;
    logic [HOUR_W-1:0]    r_s1_hour;
    logic                 r_out_valid;
    t_result              r_out;

    logic out_free;
    logic commit;
    logic in_take;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign commit     = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    ddbt_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    ddbt_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_commit     (commit),
        .i_opcode     (r_s1_opcode),
        .i_elapsed_ms (r_s1_elapsed),
        .i_hour_now   (r_s1_hour),
        .o_result     (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_s1_valid <= 1'b1;
            end else if (commit) begin
                r_s1_valid <= 1'b0;
            end
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_opcode  <= i_opcode;
            r_s1_elapsed <= i_elapsed_ms;
            r_s1_hour    <= i_hour_now;
        end
        if (commit) begin
            r_out <= result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_display_mode  = r_out.display_mode;
    assign o_mode_changed  = r_out.mode_changed;
    assign o_sleep_request = r_out.sleep_request;

endmodule
